// ===== sv/slbcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbcs_pkg
// Shared types and constants of the status LED blink-code sequencer.
// ----------------------------------------------------------------------------
package slbcs_pkg;

  // duration registers
  localparam int unsigned DUR_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DEF_SLOTS  = 16;

  localparam logic [DUR_W-1:0] RST_SHORT_ON  = 10'd90;
  localparam logic [DUR_W-1:0] RST_SHORT_OFF = 10'd170;
  localparam logic [DUR_W-1:0] RST_LONG_ON   = 10'd520;
  localparam logic [DUR_W-1:0] RST_LONG_OFF  = 10'd220;
  localparam logic [DUR_W-1:0] RST_LEAD_GAP  = 10'd300;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_GAP  = 3'd4;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ENDPOINT = 2'd1,
    OP_PROFILE  = 2'd2,
    OP_SHOW     = 2'd3
  } op_e;

  // set of pulse durations
  typedef struct packed {
    logic [DUR_W-1:0] brief_on;
    logic [DUR_W-1:0] brief_off;
    logic [DUR_W-1:0] long_on;
    logic [DUR_W-1:0] long_rest;
    logic [DUR_W-1:0] lead_pause;
  } dur_set_t;

  // compact description of the pattern being played
  typedef struct packed {
    logic       is_tr;      // transport pattern with leading long pulse
    logic [4:0] short_cnt;  // number of short pairs
    logic       suffix;     // trailing long pair present
  } pat_desc_t;

endpackage : slbcs_pkg
`default_nettype wire

// ===== sv/slbcs_dur.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbcs_dur
// Duration lookup: gives the time of one step of the current pattern from
// the pattern description and the durations captured when it was built.
// ----------------------------------------------------------------------------
module slbcs_dur
  import slbcs_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS = DEF_SLOTS
) (
  input  logic [$clog2(PATTERN_SLOTS+1)-1:0] pos_i,
  input  pat_desc_t                          desc_i,
  input  dur_set_t                           durs_i,
  output logic [DUR_W-1:0]                   dur_o
);

  localparam int unsigned PW   = $clog2(PATTERN_SLOTS + 1);
  localparam int unsigned CMPW = (PW > 6) ? PW : 6;

  logic [CMPW-1:0] pair_idx;
  logic [CMPW-1:0] short_end;
  logic            odd;
  logic            is_lead;

  // pair index and the pair where the short pulses stop
  assign pair_idx  = CMPW'(pos_i[PW-1:1]);
  assign odd       = pos_i[0];
  assign short_end = desc_i.is_tr ? CMPW'({1'b0, desc_i.short_cnt} + 6'd1)
                                  : CMPW'(desc_i.short_cnt);
  assign is_lead   = desc_i.is_tr && (pair_idx == '0);

  // select the on or off time of the pair kind
  always_comb begin
    if (is_lead) begin
      dur_o = odd ? durs_i.lead_pause : durs_i.long_on;
    end else if (pair_idx < short_end) begin
      dur_o = odd ? durs_i.brief_off : durs_i.brief_on;
    end else begin
      dur_o = odd ? durs_i.long_rest : durs_i.long_on;
    end
  end

endmodule : slbcs_dur
`default_nettype wire

// ===== sv/slbcs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbcs_core
// Playback state and its update for one item: countdown, step position,
// LED level, transport tracking and pattern rebuild on events.
// ----------------------------------------------------------------------------
module slbcs_core
  import slbcs_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS = DEF_SLOTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  op_e        op_i,
  input  logic       transport_i,
  input  logic       applied_i,
  input  logic [3:0] prof_sel_i,
  input  logic       profile_open_i,
  input  dur_set_t   durs_i,
  output logic       led_on_o,
  output logic       busy_o
);

  localparam int unsigned PW         = $clog2(PATTERN_SLOTS + 1);
  localparam int unsigned CMPW       = (PW > 6) ? PW : 6;
  localparam int unsigned SLOTS_EVEN = (PATTERN_SLOTS / 2) * 2;

  pat_desc_t        desc_q, desc_d;
  dur_set_t         snap_q, snap_d;
  logic [PW-1:0]    len_q, len_d;
  logic [PW-1:0]    step_q, step_d;
  logic [DUR_W-1:0] rem_q, rem_d;
  logic             led_q, led_d;
  logic             prev_tr_q, prev_tr_d;
  logic             tr_known_q, tr_known_d;

  logic [DUR_W-1:0] dur_cur;
  logic [DUR_W-1:0] rem_dec;
  logic [DUR_W-1:0] first_dur;
  logic             tr_changed;
  logic             build;
  pat_desc_t        new_desc;
  logic [4:0]       total_pairs;
  logic [CMPW-1:0]  full_len;
  logic [CMPW-1:0]  kept_len;

  // duration of the step at the current position
  slbcs_dur #(
    .PATTERN_SLOTS(PATTERN_SLOTS)
  ) u_dur (
    .pos_i (step_q),
    .desc_i(desc_q),
    .durs_i(snap_q),
    .dur_o (dur_cur)
  );

  // description and length of a newly built pattern
  always_comb begin
    if (op_i == OP_PROFILE) begin
      new_desc.is_tr     = 1'b0;
      new_desc.short_cnt = {1'b0, prof_sel_i} + 5'd1;
      new_desc.suffix    = profile_open_i;
    end else begin
      new_desc.is_tr     = 1'b1;
      new_desc.short_cnt = transport_i ? 5'd2 : 5'd1;
      new_desc.suffix    = (op_i == OP_SHOW) ? !applied_i : 1'b0;
    end
    total_pairs = new_desc.short_cnt + {4'd0, new_desc.is_tr} + {4'd0, new_desc.suffix};
    full_len    = CMPW'({total_pairs, 1'b0});
    kept_len    = (full_len > CMPW'(SLOTS_EVEN)) ? CMPW'(SLOTS_EVEN) : full_len;
    first_dur   = new_desc.is_tr ? durs_i.long_on : durs_i.brief_on;
  end

  assign tr_changed = !tr_known_q || (transport_i != prev_tr_q);
  assign build      = accept_i && ((op_i == OP_PROFILE) || (op_i == OP_SHOW) ||
                                   ((op_i == OP_ENDPOINT) && tr_changed));
  assign rem_dec    = rem_q - 1'b1;

  // next state for one item
  always_comb begin
    desc_d     = desc_q;
    snap_d     = snap_q;
    len_d      = len_q;
    step_d     = step_q;
    rem_d      = rem_q;
    led_d      = led_q;
    prev_tr_d  = prev_tr_q;
    tr_known_d = tr_known_q;
    if (accept_i && (op_i == OP_ENDPOINT)) begin
      prev_tr_d  = transport_i;
      tr_known_d = 1'b1;
    end
    if (build) begin
      // new pattern, first step starts at once
      desc_d = new_desc;
      snap_d = durs_i;
      len_d  = kept_len[PW-1:0];
      step_d = PW'(1);
      led_d  = 1'b1;
      rem_d  = (first_dur == '0) ? DUR_W'(1) : first_dur;
    end else if (accept_i && (op_i == OP_TICK) && (rem_q != '0)) begin
      if (rem_dec != '0) begin
        rem_d = rem_dec;
      end else if (step_q < len_q) begin
        led_d  = ~step_q[0];
        step_d = step_q + 1'b1;
        rem_d  = (dur_cur == '0) ? DUR_W'(1) : dur_cur;
      end else begin
        led_d = 1'b0;
        rem_d = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q     <= '0;
      snap_q     <= '0;
      len_q      <= '0;
      step_q     <= '0;
      rem_q      <= '0;
      led_q      <= 1'b0;
      prev_tr_q  <= 1'b0;
      tr_known_q <= 1'b0;
    end else begin
      desc_q     <= desc_d;
      snap_q     <= snap_d;
      len_q      <= len_d;
      step_q     <= step_d;
      rem_q      <= rem_d;
      led_q      <= led_d;
      prev_tr_q  <= prev_tr_d;
      tr_known_q <= tr_known_d;
    end
  end

  // result after this item
  assign led_on_o = led_d;
  assign busy_o   = rem_d != '0;

  // lit LED always has a step timing
  a_led_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_q |-> (rem_q != '0))
    else $error("LED lit with no step timing");

  // position never passes the pattern length
  a_step_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= len_q)
    else $error("step position beyond pattern length");

  // a profile event starts a lit step in the next cycle
  a_profile_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (op_i == OP_PROFILE)) |=> (led_q && (rem_q != '0) && (step_q == PW'(1))))
    else $error("profile event did not start playback");

  // a tick while idle leaves playback alone
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (op_i == OP_TICK) && (rem_q == '0)) |=>
      ($stable(step_q) && $stable(led_q) && (rem_q == '0)))
    else $error("idle tick changed playback state");

endmodule : slbcs_core
`default_nettype wire

// ===== sv/status_led_blink_code_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// status_led_blink_code_sequencer
// Status LED blink-code player driven by millisecond ticks and events.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while the output register is empty or
// drains. Each item (tick, endpoint change, profile change or direct transport
// show) updates the playback state in a single pass and its result (LED level
// and busy flag) appears in the output register on the next cycle; that
// register is the only stage between input and output, and the input stays ready
// while the result waits as long as the downstream side takes it in the same cycle.
// Patterns are held as a short description plus the durations captured when
// the pattern was built, so configuration writes do not disturb playback.
module status_led_blink_code_sequencer
  import slbcs_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS = DEF_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // transport, applied, profile idx[3:0],
                                               // profile_open, zero pad
  input  logic [1:0]           s_axis_tuser,   // operation
  // result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // led_on, busy_res, zero pad
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_wdata_i
);

  dur_set_t durs_q;
  logic     accept;
  logic     led_on;
  logic     busy;
  logic     out_valid_q, out_valid_d;
  logic     out_led_q, out_busy_q;

  // duration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      durs_q.brief_on   <= RST_SHORT_ON;
      durs_q.brief_off  <= RST_SHORT_OFF;
      durs_q.long_on    <= RST_LONG_ON;
      durs_q.long_rest  <= RST_LONG_OFF;
      durs_q.lead_pause <= RST_LEAD_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_ON:  durs_q.brief_on   <= cfg_wdata_i;
        CFG_SHORT_OFF: durs_q.brief_off  <= cfg_wdata_i;
        CFG_LONG_ON:   durs_q.long_on    <= cfg_wdata_i;
        CFG_LONG_OFF:  durs_q.long_rest  <= cfg_wdata_i;
        CFG_LEAD_GAP:  durs_q.lead_pause <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input handshake, free when the output register empties this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  slbcs_core #(
    .PATTERN_SLOTS(PATTERN_SLOTS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_e'(s_axis_tuser)),
    .transport_i    (s_axis_tdata[0]),
    .applied_i      (s_axis_tdata[1]),
    .prof_sel_i     (s_axis_tdata[5:2]),
    .profile_open_i (s_axis_tdata[6]),
    .durs_i         (durs_q),
    .led_on_o       (led_on),
    .busy_o         (busy)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_led_q  <= led_on;
      out_busy_q <= busy;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_busy_q, out_led_q};

endmodule : status_led_blink_code_sequencer
`default_nettype wire

// ===== verif/slbcs_blink_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbcs_blink_checker
// Watches the item, result and configuration ports of the blink-code
// sequencer, keeps its own copy of the playback state, predicts the LED level
// and busy flag of every accepted item and compares them with the results.
// ----------------------------------------------------------------------------
module slbcs_blink_checker
  import slbcs_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS = DEF_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input channel
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           in_data_i,    // transport, applied, profile idx[3:0],
                                             // profile_open, zero pad
  input  logic [1:0]           in_user_i,    // operation
  // result channel
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [7:0]           out_data_i,   // led_on, busy_res, zero pad
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_wdata_i,
  // status to the testbench top
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned POS_W = $clog2(PATTERN_SLOTS + 3);

  typedef struct packed {
    logic led_on;
    logic busy;
  } led_state_t;

  // shadow playback state
  dur_set_t         durations;
  logic [DUR_W-1:0] step_dur [PATTERN_SLOTS];
  logic [POS_W-1:0] pat_len;
  logic [POS_W-1:0] step_pos;
  logic [DUR_W-1:0] time_left;
  logic             led_lvl;
  logic             prev_link;
  logic             transport_seen;

  led_state_t       led_expect_q [$];
  led_state_t       oldest_led;
  int unsigned      failures = 0;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    failures++;
  endtask

  // a pair that no longer fits is dropped
  function automatic void add_pulse_pair(logic [DUR_W-1:0] on_t, logic [DUR_W-1:0] off_t);
    if (pat_len + 2 <= PATTERN_SLOTS) begin
      step_dur[pat_len]     = on_t;
      step_dur[pat_len + 1] = off_t;
      pat_len               = pat_len + 2'd2;
    end
  endfunction

  // even steps lit, odd steps dark, zero duration lasts one tick
  function automatic void play_next_step();
    if (step_pos < pat_len) begin
      led_lvl   = ~step_pos[0];
      time_left = (step_dur[step_pos] == '0) ? DUR_W'(1) : step_dur[step_pos];
      step_pos  = step_pos + 1'b1;
    end else begin
      led_lvl   = 1'b0;
      time_left = '0;
    end
  endfunction

  // long lead, one short for usb or two for ble, long suffix if not applied
  function automatic void load_transport_code(logic transport, logic applied);
    pat_len = '0;
    add_pulse_pair(durations.long_on, durations.lead_pause);
    add_pulse_pair(durations.brief_on, durations.brief_off);
    if (transport)
      add_pulse_pair(durations.brief_on, durations.brief_off);
    if (!applied)
      add_pulse_pair(durations.long_on, durations.long_rest);
    step_pos = '0;
    play_next_step();
  endfunction

  // index+1 shorts, long suffix when the profile is open
  function automatic void load_profile_code(logic [3:0] index, logic open_prof);
    pat_len = '0;
    for (int i = 0; i <= index; i++)
      add_pulse_pair(durations.brief_on, durations.brief_off);
    if (open_prof)
      add_pulse_pair(durations.long_on, durations.long_rest);
    step_pos = '0;
    play_next_step();
  endfunction

  function automatic led_state_t advance_on_item(op_e op, logic [7:0] data);
    logic       transport;
    logic       applied;
    logic [3:0] index;
    logic       open_prof;
    logic       changed;
    led_state_t res;
    transport = data[0];
    applied   = data[1];
    index     = data[5:2];
    open_prof = data[6];
    case (op)
      OP_TICK: begin
        if (time_left != '0) begin
          time_left = time_left - 1'b1;
          if (time_left == '0)
            play_next_step();
        end
      end
      OP_ENDPOINT: begin
        // only a new transport restarts playback
        changed        = !transport_seen || (transport != prev_link);
        prev_link      = transport;
        transport_seen = 1'b1;
        if (changed)
          load_transport_code(transport, 1'b1);
      end
      OP_PROFILE: load_profile_code(index, open_prof);
      default:    load_transport_code(transport, applied);
    endcase
    res.led_on = led_lvl;
    res.busy   = (time_left != '0);
    return res;
  endfunction

  // predict, compare and track configuration
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      durations      = '{brief_on: RST_SHORT_ON, brief_off: RST_SHORT_OFF,
                         long_on: RST_LONG_ON, long_rest: RST_LONG_OFF,
                         lead_pause: RST_LEAD_GAP};
      pat_len        = '0;
      step_pos       = '0;
      time_left      = '0;
      led_lvl        = 1'b0;
      prev_link      = 1'b0;
      transport_seen = 1'b0;
      led_expect_q.delete();
      pending_o      <= 0;
      fail_count_o   <= failures;
    end else begin
      // results first, so one arriving with nothing queued is caught
      if (out_valid_i && out_ready_i) begin
        if (led_expect_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no item pending", out_data_i));
        end else begin
          oldest_led = led_expect_q.pop_front();
          if (out_data_i[0] !== oldest_led.led_on)
            report_mismatch($sformatf("led_on expected %0b got %0b",
                                      oldest_led.led_on, out_data_i[0]));
          if (out_data_i[1] !== oldest_led.busy)
            report_mismatch($sformatf("busy_res expected %0b got %0b",
                                      oldest_led.busy, out_data_i[1]));
        end
      end
      if (in_valid_i && in_ready_i)
        led_expect_q.push_back(advance_on_item(op_e'(in_user_i), in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_ON:  durations.brief_on   = cfg_wdata_i;
          CFG_SHORT_OFF: durations.brief_off  = cfg_wdata_i;
          CFG_LONG_ON:   durations.long_on    = cfg_wdata_i;
          CFG_LONG_OFF:  durations.long_rest  = cfg_wdata_i;
          CFG_LEAD_GAP:  durations.lead_pause = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o    <= led_expect_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the status LED blink-code sequencer: a directed opening over
// every event kind and corner of the pattern store, then random ticks and
// events under several duration settings and handshake idling modes. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import slbcs_pkg::*;

  localparam int unsigned SLOTS         = DEF_SLOTS;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 215;

  localparam logic [CFG_IDX_W-1:0] DUR_REGS [5] = '{CFG_SHORT_ON, CFG_SHORT_OFF,
                                                    CFG_LONG_ON, CFG_LONG_OFF,
                                                    CFG_LEAD_GAP};

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic [7:0]           s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = OP_TICK;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_SHORT_ON;
  logic [DUR_W-1:0]     cfg_wdata_i   = '0;
  wire                  s_axis_tready;
  wire                  m_axis_tvalid;
  wire  [7:0]           m_axis_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_flip     = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;
  int unsigned fail_count;
  int unsigned pending;

  status_led_blink_code_sequencer #(
    .PATTERN_SLOTS (SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  slbcs_blink_checker #(
    .PATTERN_SLOTS (SLOTS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reset, once
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_flip != hold_seen) begin
      hold_seen     <= hold_flip;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(op_e op, logic transport, logic applied, logic [3:0] index,
                           logic open_prof);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, open_prof, index, applied, transport};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all duration registers with values in [lo, hi]
  task automatic program_durations(int unsigned lo, int unsigned hi);
    foreach (DUR_REGS[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= DUR_REGS[i];
      cfg_wdata_i <= DUR_W'($urandom_range(hi, lo));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin
    op_e op;
    wait (rst_ni);
    @(posedge clk_i);
    set_idling(38, 71);

    // reset durations: idle tick, first endpoint, same endpoint again
    send_item(OP_TICK, 1'b1, 1'b0, 4'hF, 1'b1);
    send_item(OP_ENDPOINT, 1'b0, 1'b1, 4'h0, 1'b0);
    send_item(OP_ENDPOINT, 1'b0, 1'b0, 4'hA, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b1, 4'h5, 1'b0);

    // zero durations: every step lasts one tick
    drain_results();
    program_durations(0, 0);
    send_item(OP_ENDPOINT, 1'b1, 1'b1, 4'h3, 1'b0);
    repeat (4) send_item(OP_TICK, 1'b1, 1'b1, 4'hF, 1'b1);
    send_item(OP_SHOW, 1'b0, 1'b0, 4'h0, 1'b0);
    send_item(OP_SHOW, 1'b1, 1'b1, 4'hF, 1'b1);
    send_item(OP_PROFILE, 1'b1, 1'b1, 4'h0, 1'b0);
    repeat (2) send_item(OP_TICK, 1'b0, 1'b0, 4'h0, 1'b0);
    // full store, exact fit, dropped suffix
    send_item(OP_PROFILE, 1'b0, 1'b0, 4'hF, 1'b1);
    send_item(OP_PROFILE, 1'b1, 1'b0, 4'h6, 1'b1);
    send_item(OP_PROFILE, 1'b0, 1'b1, 4'h7, 1'b1);
    repeat (8) send_item(OP_TICK, 1'b1, 1'b0, 4'h9, 1'b0);

    // random ticks and events under several settings
    for (int k = 0; k < 6; k++) begin
      drain_results();
      case (k)
        0: program_durations(1, 4);
        1: program_durations(1, 1);
        2: program_durations(0, 6);
        3: program_durations(1023, 1023);
        4: program_durations(1, 1023);
        default: program_durations(1, 5);
      endcase
      if (k < 2)
        set_idling(38, 71);
      else if (k < 4)
        set_idling(71, 38);
      else
        set_idling(0, 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (k == 1 && n == 60)
          hold_flip <= ~hold_flip;
        if (k == 4 && n == 100)
          drain_results();
        if ($urandom_range(99) < 88)
          op = OP_TICK;
        else
          op = op_e'($urandom_range(3, 1));
        send_item(op, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  4'($urandom_range(15)), 1'($urandom_range(1)));
      end
    end

    drain_results();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
